// ----- rtl/ptat_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptat_pkg
// Shared types and constants of the peer liveness aging table.
// ----------------------------------------------------------------------------
package ptat_pkg;

	localparam int ADDR_W     = 32;
	localparam int TIME_W     = 32;
	localparam int INTERVAL_W = 16;
	localparam int COUNT_W    = 7;
	localparam int STATUS_W   = 2;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(30);
	localparam logic [TIME_W-1:0]     GRACE_SECONDS  = TIME_W'(10);
	localparam logic [COUNT_W-1:0]    COUNT_MAX      = COUNT_W'(127);

	localparam logic OP_PING  = 1'b0;
	localparam logic OP_SWEEP = 1'b1;

	localparam logic [STATUS_W-1:0] ST_REFRESHED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ADDED     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SWEPT     = 2'd3;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] address;
		logic [TIME_W-1:0] last_seen;
	} entry_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  deleted_count;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

// ----- rtl/ptat_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptat_mem
// Single-port-write, single-port-read table memory with registered read data.
// ----------------------------------------------------------------------------
module ptat_mem #(
	parameter int TABLE_DEPTH = 64,
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IW-1:0]    waddr,
	input  ptat_pkg::entry_t wdata,
	input  logic             re,
	input  logic [IW-1:0]    raddr,
	output ptat_pkg::entry_t rdata
);

	ptat_pkg::entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/ptat_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptat_scan
// Sequencer: clearing pass, lookup/insert scan for pings, aging scan for sweeps.
// ----------------------------------------------------------------------------
module ptat_scan #(
	parameter int TABLE_DEPTH = 64,
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CW = IW + 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ptat_pkg::INTERVAL_W-1:0]     cfg_wdata,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic                                req_op,
	input  logic [ptat_pkg::ADDR_W-1:0]         req_ip,
	input  logic [ptat_pkg::TIME_W-1:0]         req_now,
	output logic                                mem_re,
	output logic [IW-1:0]                       mem_raddr,
	input  ptat_pkg::entry_t                    mem_rdata,
	output logic                                mem_we,
	output logic [IW-1:0]                       mem_waddr,
	output ptat_pkg::entry_t                    mem_wdata,
	output logic                                res_valid,
	input  logic                                res_ready,
	output ptat_pkg::result_t                   res
);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
	localparam logic [CW-1:0] CNT_END  = CW'(TABLE_DEPTH);

	state_t                              state_q;
	logic [CW-1:0]                       cnt_q;
	logic                                vld_s1;
	logic [IW-1:0]                       idx_s1;
	logic                                op_q;
	logic [ptat_pkg::ADDR_W-1:0]         ip_q;
	logic [ptat_pkg::TIME_W-1:0]         now_q;
	logic [ptat_pkg::INTERVAL_W-1:0]     interval_q;
	logic                                free_found_q;
	logic [IW-1:0]                       free_idx_q;
	logic [ptat_pkg::COUNT_W-1:0]        count_q;
	ptat_pkg::result_t                   res_q;

	logic                                rd_issue;
	logic [ptat_pkg::TIME_W+1:0]         limit;
	logic                                expired;
	logic                                hit;
	logic                                is_last;
	logic                                free_here;
	logic                                age_out;
	logic                                can_add;
	logic [ptat_pkg::COUNT_W-1:0]        count_next;
	ptat_pkg::entry_t                    new_entry;

	assign rd_issue  = (state_q == S_SCAN) && (cnt_q != CNT_END);
	assign mem_re    = rd_issue;
	assign mem_raddr = cnt_q[IW-1:0];

	// 34-bit sum so the aging test never wraps
	assign limit   = {2'b00, mem_rdata.last_seen} + {18'd0, interval_q}
	               + {2'b00, ptat_pkg::GRACE_SECONDS};
	assign expired = limit < {2'b00, now_q};

	assign hit       = vld_s1 && (op_q == ptat_pkg::OP_PING) && mem_rdata.valid
	                && (mem_rdata.address == ip_q);
	assign is_last   = vld_s1 && (idx_s1 == LAST_IDX);
	assign free_here = vld_s1 && !mem_rdata.valid && !free_found_q;
	assign age_out   = vld_s1 && (op_q == ptat_pkg::OP_SWEEP) && mem_rdata.valid
	                && expired;
	assign can_add   = free_found_q || free_here;

	assign count_next = (age_out && (count_q != ptat_pkg::COUNT_MAX))
	                  ? count_q + ptat_pkg::COUNT_W'(1) : count_q;

	assign new_entry = '{valid: 1'b1, address: ip_q, last_seen: now_q};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = '0;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q[IW-1:0];
		end else if (hit) begin
			mem_we    = 1'b1;
			mem_wdata = new_entry;
		end else if (age_out) begin
			// invalid word drops the entry
			mem_we = 1'b1;
		end else if (is_last && (op_q == ptat_pkg::OP_PING) && can_add) begin
			mem_we    = 1'b1;
			mem_waddr = free_found_q ? free_idx_q : idx_s1;
			mem_wdata = new_entry;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= ptat_pkg::INTERVAL_RESET;
		end else if (cfg_we) begin
			interval_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cnt_q        <= '0;
			vld_s1       <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			// kill the read in flight once a hit ends the scan
			vld_s1 <= rd_issue && !hit;
			case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q[IW-1:0] == LAST_IDX) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						cnt_q        <= '0;
						free_found_q <= 1'b0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_issue) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (free_here) begin
						free_found_q <= 1'b1;
					end
					if (hit || is_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IW-1:0];
		if (req_valid && req_ready) begin
			op_q    <= req_op;
			ip_q    <= req_ip;
			now_q   <= req_now;
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
		if (free_here) begin
			free_idx_q <= idx_s1;
		end
		if (hit) begin
			res_q <= '{deleted_count: '0, status: ptat_pkg::ST_REFRESHED};
		end else if (is_last) begin
			if (op_q == ptat_pkg::OP_SWEEP) begin
				res_q <= '{deleted_count: count_next, status: ptat_pkg::ST_SWEPT};
			end else if (can_add) begin
				res_q <= '{deleted_count: '0, status: ptat_pkg::ST_ADDED};
			end else begin
				res_q <= '{deleted_count: '0, status: ptat_pkg::ST_FULL};
			end
		end
	end

endmodule

// ----- rtl/ptat_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptat_out
// Output register holding one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ptat_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ptat_pkg::result_t in_res,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata
);

	logic              valid_q;
	ptat_pkg::result_t data_q;

	assign in_ready = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {7'd0, data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= in_res;
		end
	end

endmodule

// ----- rtl/peer_liveness_aging_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_liveness_aging_table
// Peer table keyed by IPv4 address with last-seen timestamps and aging sweep.
// ----------------------------------------------------------------------------
// Every sweep, and every ping that misses, walks the whole table through one
// memory read port, one entry per cycle; a ping that hits stops the scan at
// the matching slot. After reset a clearing pass that writes every slot
// invalid runs before the first request is taken; the config register may
// be written during it. A ping to an address not present while all slots
// are valid is dropped and answered with the full status. One result is
// returned per request; a finished result waits in an output register, so
// the next request is taken while it is pending.
module peer_liveness_aging_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,     // ping_interval
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,       // [31:0] peer_ip, [63:32] now
	input  logic        s_tuser,       // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata        // [1:0] status, [8:2] deleted_count
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic              mem_re;
	logic [IW-1:0]     mem_raddr;
	ptat_pkg::entry_t  mem_rdata;
	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	ptat_pkg::entry_t  mem_wdata;
	logic              res_valid;
	logic              res_ready;
	ptat_pkg::result_t res;

	ptat_mem #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	ptat_scan #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.req_op   (s_tuser),
		.req_ip   (s_tdata[31:0]),
		.req_now  (s_tdata[63:32]),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	ptat_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(res_valid),
		.in_ready(res_ready),
		.in_res  (res),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

// ----- tb/tb_peer_liveness_aging_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_peer_liveness_aging_table
// Self-checking bench for the peer liveness aging table. Pings and aging
// sweeps go in on the request stream. An in-bench copy of the peer table
// predicts status and deleted count for each accepted request. Both stream
// sides idle at random, and ping_interval is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_peer_liveness_aging_table;
	import ptat_pkg::*;

	localparam int DEPTH        = 64;
	localparam int SUM_W        = TIME_W + 2;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = 80;

	class liveness_board;
		logic [INTERVAL_W-1:0] ping_interval;
		bit                    occupied [DEPTH];
		logic [ADDR_W-1:0]     peer_addr [DEPTH];
		logic [TIME_W-1:0]     last_heard [DEPTH];
		result_t               peer_answers [$];
		int errors;
		int checked;
		int n_added;
		int n_refreshed;
		int n_full;
		int n_sweeps;
		int widest_sweep;

		function new();
			ping_interval = INTERVAL_RESET;
		endfunction

		function logic [STATUS_W-1:0] touch_peer(logic [ADDR_W-1:0] ip, logic [TIME_W-1:0] now);
			int free_slot;
			int i;
			free_slot = -1;
			for (i = 0; i < DEPTH; i++) begin
				if (occupied[i]) begin
					if (peer_addr[i] == ip) begin
						last_heard[i] = now;
						n_refreshed++;
						return ST_REFRESHED;
					end
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (free_slot < 0) begin
				n_full++;
				return ST_FULL;
			end
			occupied[free_slot]   = 1'b1;
			peer_addr[free_slot]  = ip;
			last_heard[free_slot] = now;
			n_added++;
			return ST_ADDED;
		endfunction

		function logic [COUNT_W-1:0] age_out_peers(logic [TIME_W-1:0] now);
			logic [SUM_W-1:0] deadline;
			int removed;
			int i;
			removed = 0;
			for (i = 0; i < DEPTH; i++) begin
				if (occupied[i]) begin
					// widen so the deadline never wraps
					deadline = SUM_W'(last_heard[i]) + SUM_W'(ping_interval) +
						SUM_W'(GRACE_SECONDS);
					if (deadline < SUM_W'(now)) begin
						occupied[i] = 1'b0;
						if (removed < COUNT_MAX)
							removed++;
					end
				end
			end
			n_sweeps++;
			if (removed > widest_sweep)
				widest_sweep = removed;
			return COUNT_W'(removed);
		endfunction

		function void note_request(logic op, logic [ADDR_W-1:0] ip, logic [TIME_W-1:0] now);
			result_t answer;
			answer = '0;
			if (op == OP_PING) begin
				answer.status = touch_peer(ip, now);
			end else begin
				answer.status        = ST_SWEPT;
				answer.deleted_count = age_out_peers(now);
			end
			peer_answers.push_back(answer);
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_result(logic [15:0] data);
			result_t want;
			result_t got;
			got = data[8:0];
			checked++;
			if (peer_answers.size() == 0) begin
				report($sformatf("unexpected result %h", data));
			end else begin
				want = peer_answers.pop_front();
				if (got.status !== want.status)
					report($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.deleted_count !== want.deleted_count)
					report($sformatf("deleted_count %0d, want %0d",
						got.deleted_count, want.deleted_count));
				if (data[15:9] !== '0)
					report($sformatf("padding bits %h not zero", data[15:9]));
			end
		endtask
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;     // [31:0] peer_ip, [63:32] now
	logic        s_tuser   = 1'b0;   // op
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;            // [1:0] status, [8:2] deleted_count

	liveness_board sb = new();
	int  idle_cycles = 0;
	int  rx_hold     = 0;
	int  rx_seen     = 0;
	bit  rx_steady   = 1'b0;
	bit  tx_steady   = 1'b0;
	int  n_settings  = 0;

	peer_liveness_aging_table #(.TABLE_DEPTH(DEPTH)) dut (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata
	);

	always #6 clk = ~clk;

	function automatic int stall_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $urandom_range(1, 3);
		else if (r < 85)
			return $urandom_range(4, 12);
		else if (r < 97)
			return $urandom_range(20, 60);
		return $urandom_range(80, 200);
	endfunction

	// result side: stall after some results and now and then out of the blue
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold  <= rx_hold - 1;
		end else begin
			m_tready <= 1'b1;
			if (!rx_steady && (sb.checked != rx_seen ? $urandom_range(0, 2) == 0
					: $urandom_range(0, 24) == 0))
				rx_hold <= stall_length();
		end
		if (sb.checked != rx_seen && $urandom_range(0, 19) == 0)
			rx_steady <= !rx_steady;
		rx_seen <= sb.checked;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			sb.check_result(m_tdata);
		if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("no handshake for %0d cycles", IDLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_interval(input logic [INTERVAL_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.ping_interval = value;
		n_settings++;
	endtask

	// call at a falling edge; returns at the falling edge after the request is taken
	task automatic send_request(input logic op, input logic [ADDR_W-1:0] ip,
			input logic [TIME_W-1:0] now);
		int gap;
		gap = (tx_steady || $urandom_range(0, 2) == 0) ? 0 : stall_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {now, ip};
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_request(op, ip, now);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.peer_answers.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input logic [INTERVAL_W-1:0] interval, input int pool_size,
			input int count, input int sweep_odds, input logic [TIME_W-1:0] base,
			input int step_max, input int reach);
		logic [ADDR_W-1:0] pool [$];
		logic [TIME_W-1:0] cur;
		logic [TIME_W-1:0] stamp;
		int k;
		wait_idle();
		write_interval(interval);
		for (k = 0; k < pool_size; k++)
			pool.push_back($urandom());
		cur = base;
		for (k = 0; k < count; k++) begin
			cur = cur + $urandom_range(0, step_max);
			if ($urandom_range(0, 15) == 0) begin
				send_request(1'($urandom_range(0, 1)), $urandom(), $urandom());
			end else if ($urandom_range(1, sweep_odds) == 1) begin
				stamp = cur;
				if (reach > 0 && $urandom_range(0, 1) == 1)
					stamp = cur + $urandom_range(0, reach);
				send_request(OP_SWEEP, $urandom(), stamp);
			end else begin
				send_request(OP_PING, pool[$urandom_range(0, pool_size - 1)], cur);
			end
			if ($urandom_range(0, 39) == 0)
				tx_steady = !tx_steady;
		end
	endtask

	initial begin
		int span;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// edge values, refresh, lowest free slot reuse, sweep boundary
		write_interval('0);
		send_request(OP_PING,  32'h0000_0000, 32'd100);
		send_request(OP_PING,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_PING,  32'h0000_0000, 32'd0);
		send_request(OP_PING,  32'hA5A5_A5A5, 32'd5);
		send_request(OP_SWEEP, 32'h0000_0000, 32'd10);
		send_request(OP_SWEEP, 32'h0000_0000, 32'd11);
		send_request(OP_PING,  32'h5A5A_5A5A, 32'd7);
		send_request(OP_PING,  32'hFFFF_FFFF, 32'd1);
		send_request(OP_SWEEP, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
		send_request(OP_SWEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_idle();
		write_interval('1);
		// timestamp near the top must not wrap past the sweep time
		send_request(OP_PING,  32'h1234_5678, 32'hFFFF_FFF0);
		send_request(OP_SWEEP, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(OP_PING,  32'h0000_0000, 32'd0);
		send_request(OP_SWEEP, 32'h0000_0000, 32'd65545);
		send_request(OP_SWEEP, 32'h0000_0000, 32'd65546);

		// fill the table past full, then age every slot out at once
		run_phase('1, 90, 170, 25, 32'd1000, 3, 0);
		send_request(OP_SWEEP, 32'h0000_0000, 32'hFFFF_FFFF);
		run_phase('0, 24, 150, 5, $urandom(), 6, 20);
		run_phase(INTERVAL_RESET, 48, 140, 7, 32'hFFFF_FF00, 12, 100);
		span = $urandom_range(1, 200);
		run_phase(INTERVAL_W'(span), 70, 140, 8, $urandom(), 10, 2 * span + 40);

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("requests checked %0d: %0d added, %0d refreshed, %0d table full, %0d sweeps",
			sb.checked, sb.n_added, sb.n_refreshed, sb.n_full, sb.n_sweeps);
		$display("largest sweep removed %0d peers over %0d ping_interval settings",
			sb.widest_sweep, n_settings);
		if (sb.errors == 0 && sb.peer_answers.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
